// File: sv/csc_pkg.sv
// Package for the CORDIC sine/cosine unit: widths, fold constants,
// the arctangent table and the stage record that flows down the cell chain.
// No dependencies.
package csc_pkg;

   localparam int ITERATIONS = 13;
   localparam int ANGLE_W    = 15;
   localparam int OUT_W      = 16;
   localparam int XY_W       = 18;
   localparam int Z_W        = 16;
   localparam int ATAN_W     = 13;
   localparam int SHIFT_W    = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

   localparam logic [ANGLE_W-1:0] QUARTER       = 15'd8192;
   localparam logic [ANGLE_W-1:0] HALF          = 15'd16384;
   localparam logic [ANGLE_W-1:0] THREE_QUARTER = 15'd24576;
   localparam logic [ANGLE_W-1:0] TURN_MAX      = 15'd32767;

   localparam logic signed [XY_W-1:0] START_LEN = 18'sd19898;
   localparam logic signed [XY_W-1:0] SAT_MAX   = 18'sd32767;
   localparam logic signed [XY_W-1:0] SAT_MIN   = -18'sd32768;

   localparam logic [ATAN_W-1:0] ATAN_TABLE [13] = '{
      13'd4096, 13'd2418, 13'd1277, 13'd648, 13'd326, 13'd163, 13'd81,
      13'd41, 13'd20, 13'd10, 13'd5, 13'd3, 13'd1
   };

   typedef struct packed {
      logic                   valid;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic signed [Z_W-1:0]  target;
      logic                   neg_sin;
      logic                   neg_cos;
   } csc_stage_type;

endpackage

// File: sv/csc_if.sv
// Valid/ready channel interfaces for the CORDIC sine/cosine unit.
// Depends on csc_pkg for the field widths.
interface csc_req_if;
   import csc_pkg::*;
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] angle;
   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

interface csc_rsp_if;
   import csc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] sine;
   logic signed [OUT_W-1:0] cosine;
   modport source (output valid, output sine, output cosine, input ready);
   modport sink   (input valid, input sine, input cosine, output ready);
endinterface

// File: sv/csc_fold.sv
// Quadrant fold stage: maps the angle into the first quadrant and loads
// the start vector. Depends on csc_pkg.
module csc_fold
   import csc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [ANGLE_W-1:0] angle,
   output csc_stage_type      stage_out
);

   csc_stage_type stage_ff, stage_in;
   logic [Z_W-1:0] a_ext;

   always_comb begin
      a_ext = Z_W'(angle);
      stage_in         = '0;
      stage_in.valid   = in_valid;
      stage_in.x       = START_LEN;
      stage_in.y       = '0;
      stage_in.z       = '0;
      if (angle < QUARTER) begin
         stage_in.target = a_ext;
      end else if (angle < HALF) begin
         stage_in.target  = Z_W'(HALF) - a_ext;
         stage_in.neg_cos = 1'b1;
      end else if (angle < THREE_QUARTER) begin
         stage_in.target  = a_ext - Z_W'(HALF);
         stage_in.neg_sin = 1'b1;
         stage_in.neg_cos = 1'b1;
      end else begin
         // The mirror uses the full-scale code, one short of an exact turn.
         stage_in.target  = Z_W'(TURN_MAX) - a_ext;
         stage_in.neg_sin = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: sv/csc_cell.sv
// One CORDIC rotation cell: a shift-add micro-rotation and a register.
// Depends on csc_pkg.
module csc_cell
   import csc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [SHIFT_W-1:0] shift_amt,
   input  logic [ATAN_W-1:0]  atan_step,
   input  csc_stage_type      stage_in,
   output csc_stage_type      stage_out
);

   csc_stage_type stage_ff, stage_nx_in;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  step;

   always_comb begin
      // Arithmetic shifts round toward minus infinity.
      xs   = stage_in.x >>> shift_amt;
      ys   = stage_in.y >>> shift_amt;
      step = $signed(Z_W'(atan_step));
      stage_nx_in = stage_in;
      // Rotate positively only while the accumulated angle is below target.
      if (stage_in.z < stage_in.target) begin
         stage_nx_in.x = stage_in.x - ys;
         stage_nx_in.y = stage_in.y + xs;
         stage_nx_in.z = stage_in.z + step;
      end else begin
         stage_nx_in.x = stage_in.x + ys;
         stage_nx_in.y = stage_in.y - xs;
         stage_nx_in.z = stage_in.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_nx_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: sv/csc_out.sv
// Output stage: restores the quadrant signs, saturates to Q15 and holds
// the result until it is taken. Depends on csc_pkg.
module csc_out
   import csc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  csc_stage_type           stage_in,
   input  logic                    out_ready,
   output logic                    advance,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] sine,
   output logic signed [OUT_W-1:0] cosine
);

   logic                    valid_ff;
   logic signed [OUT_W-1:0] sine_ff, cosine_ff, sine_in, cosine_in;
   logic signed [XY_W-1:0]  ys, xs;

   function automatic logic signed [OUT_W-1:0] sat16(input logic signed [XY_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_MAX) begin
         r = OUT_W'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         r = OUT_W'(SAT_MIN);
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      ys = stage_in.neg_sin ? -stage_in.y : stage_in.y;
      xs = stage_in.neg_cos ? -stage_in.x : stage_in.x;
      sine_in   = sat16(ys);
      cosine_in = sat16(xs);
   end

   assign advance = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign out_valid = valid_ff;
   assign sine      = sine_ff;
   assign cosine    = cosine_ff;

endmodule

// File: sv/cordic_sine_cosine_unit.sv
// Top level of the CORDIC sine/cosine unit (rotation mode).
// Depends on csc_pkg, csc_if, csc_fold, csc_cell and csc_out.
//
//   Channel   Direction  Handshake          Payload
//   req_ch    in         valid / ready      angle  [14:0] unsigned, 32768 = full turn
//   rsp_ch    out        valid / ready      sine, cosine [15:0] signed Q15
//
// One request is taken every cycle unless a waiting response stalls the chain; each
// response passes through one fold stage, one cell per iteration and one sign and
// saturation stage.
// Reset is synchronous and active high; it clears only the valid bits.
// The whole chain moves together: when a response waits and rsp_ch.ready
// is low, every stage holds and req_ch.ready drops in the same cycle.
module cordic_sine_cosine_unit
   import csc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   csc_req_if.sink   req_ch,
   csc_rsp_if.source rsp_ch
);

   // Stage 0 is the fold output; stage k+1 is the output of cell k.
   csc_stage_type stage [ITERATIONS+1];
   logic          advance;

   // A request enters whenever the chain moves, so ready equals advance.
   assign req_ch.ready = advance;

   csc_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .angle     (req_ch.angle),
      .stage_out (stage[0])
   );

   // Each cell shifts by its own position and uses its own table entry.
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      csc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .shift_amt (SHIFT_W'(i)),
         .atan_step (ATAN_TABLE[i]),
         .stage_in  (stage[i]),
         .stage_out (stage[i+1])
      );
   end

   // The output stage owns the response register and decides when the
   // chain may move.
   csc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (stage[ITERATIONS]),
      .out_ready (rsp_ch.ready),
      .advance   (advance),
      .out_valid (rsp_ch.valid),
      .sine      (rsp_ch.sine),
      .cosine    (rsp_ch.cosine)
   );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for cordic_sine_cosine_unit: a scoreboard class predicts sine and
// cosine per accepted request, and plain tasks drive bursts of angles against a stalling sink.
// Depends on csc_pkg, csc_if and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
   import csc_pkg::*;

   // Rotation and fold constants for the predictor, written out from the algorithm.
   localparam int ROT_STEPS  = 13;
   localparam int ROT_START  = 19898;
   localparam int FOLD_Q1    = 8192;
   localparam int FOLD_Q2    = 16384;
   localparam int FOLD_Q3    = 24576;
   localparam int FOLD_TOP   = 32767;
   localparam int Q15_MAX    = 32767;
   localparam int Q15_MIN    = -32768;
   localparam int PIPE_DEPTH = 15;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_REQUESTS = 400;

   typedef struct packed {
      logic [ANGLE_W-1:0]      angle;
      logic signed [OUT_W-1:0] sine;
      logic signed [OUT_W-1:0] cosine;
   } sincos_pair_type;

   // Holds the predicted sine/cosine pairs in request order and checks responses against them.
   class sincos_scoreboard;
      sincos_pair_type expected_pairs[$];
      int              errors;

      function new();
         errors = 0;
      endfunction

      // Rotation-mode CORDIC on plain ints; >>> on a signed int rounds toward minus infinity.
      function sincos_pair_type predict_sincos(logic [ANGLE_W-1:0] angle);
         int              rot_atan[ROT_STEPS];
         int              a;
         int              target;
         int              x;
         int              y;
         int              z;
         int              xs;
         int              ys;
         bit              flip_sin;
         bit              flip_cos;
         sincos_pair_type pair;
         rot_atan = '{4096, 2418, 1277, 648, 326, 163, 81, 41, 20, 10, 5, 3, 1};
         a        = int'(angle);
         flip_sin = 1'b0;
         flip_cos = 1'b0;
         if (a < FOLD_Q1) begin
            target = a;
         end else if (a < FOLD_Q2) begin
            target   = FOLD_Q2 - a;
            flip_cos = 1'b1;
         end else if (a < FOLD_Q3) begin
            target   = a - FOLD_Q2;
            flip_sin = 1'b1;
            flip_cos = 1'b1;
         end else begin
            // The fourth quadrant mirrors about 32767, one code short of a true mirror.
            target   = FOLD_TOP - a;
            flip_sin = 1'b1;
         end
         x = ROT_START;
         y = 0;
         z = 0;
         for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z < target) begin
               x = x - ys;
               y = y + xs;
               z = z + rot_atan[i];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z - rot_atan[i];
            end
         end
         if (flip_sin) y = -y;
         if (flip_cos) x = -x;
         if (y > Q15_MAX) y = Q15_MAX;
         if (y < Q15_MIN) y = Q15_MIN;
         if (x > Q15_MAX) x = Q15_MAX;
         if (x < Q15_MIN) x = Q15_MIN;
         pair.angle  = angle;
         pair.sine   = OUT_W'(y);
         pair.cosine = OUT_W'(x);
         return pair;
      endfunction

      function void note_request(logic [ANGLE_W-1:0] angle);
         expected_pairs.push_back(predict_sincos(angle));
      endfunction

      function void check_response(logic signed [OUT_W-1:0] sine,
                                   logic signed [OUT_W-1:0] cosine);
         sincos_pair_type want;
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected response, expected none, got sine %0d cosine %0d",
                     $time, sine, cosine);
            errors++;
            return;
         end
         want = expected_pairs.pop_front();
         if (sine !== want.sine) begin
            $display("%0t: angle %0d sine mismatch, expected %0d, got %0d",
                     $time, want.angle, want.sine, sine);
            errors++;
         end
         if (cosine !== want.cosine) begin
            $display("%0t: angle %0d cosine mismatch, expected %0d, got %0d",
                     $time, want.angle, want.cosine, cosine);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pairs.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   csc_req_if req_ch();
   csc_rsp_if rsp_ch();

   cordic_sine_cosine_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sincos_scoreboard sb;
   int               idle_cycles;
   logic [15:0]      stall_pattern;
   int               stall_left;

   // Free-running clock, 20 ns period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every input of the unit has a known value from time zero on.
   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.angle  = '0;
      rsp_ch.ready  = 1'b0;
      stall_left    = 0;
      stall_pattern = 16'hFFFF;
      idle_cycles   = 0;
      sb            = new();
   end

   // The sink stalls on a rotating 16-bit pattern that is reloaded when its random run ends.
   // Some windows never stall, some stall in long runs, some alternate, some at random; every pattern keeps
   // at least one ready cycle so no stall lasts longer than the pattern itself.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 4))
            0:       stall_pattern = 16'hFFFF;
            1:       stall_pattern = 16'h0001;
            2:       stall_pattern = 16'hAAAA;
            default: stall_pattern = 16'($urandom) | 16'h0001;
         endcase
         stall_left = $urandom_range(24, 96);
      end
      rsp_ch.ready  = stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      stall_left--;
   end

   // Both channels are sampled at the rising edge, where the values from the falling edge
   // are settled and the unit's own registers have not moved yet.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.angle);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.sine, rsp_ch.cosine);
      end
   end

   // Watchdog: counts cycles in which neither channel moves a request or a response.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("[cordic_sine_cosine_unit] ERROR");
      $finish;
   end

   // Presents one angle at the falling edge and holds it until the unit takes it.
   // Valid is left high so a following request can go back to back.
   task automatic send_angle(input logic [ANGLE_W-1:0] angle);
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.angle = angle;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drops valid for a number of cycles; the payload is scrambled to show it is ignored.
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_ch.valid = 1'b0;
      req_ch.angle = ANGLE_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Random angles: mostly uniform, some pinned near the quadrant seams and the ends,
   // where the fold and the equality case of the step direction matter most.
   function automatic logic [ANGLE_W-1:0] pick_angle();
      int seam;
      if ($urandom_range(0, 3) == 0) begin
         seam = $urandom_range(0, 4) * FOLD_Q1;
         return ANGLE_W'(seam + $urandom_range(0, 6) - 3);
      end
      return ANGLE_W'($urandom_range(0, FOLD_TOP));
   endfunction

   initial begin
      logic [ANGLE_W-1:0] directed_angles[$];
      int                 burst;
      int                 sent;

      // Synchronous reset, held from time zero and released at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: both ends of the range, both sides of every quadrant seam,
      // the exact mirror points, the fourth-quadrant fold just below 32767, and
      // alternating bit patterns.
      directed_angles = '{
         15'd0, 15'd1, 15'd2048, 15'd4096, 15'd8191, 15'd8192, 15'd8193,
         15'd12288, 15'd16383, 15'd16384, 15'd16385, 15'd20480, 15'd24575,
         15'd24576, 15'd24577, 15'd28672, 15'd32766, 15'd32767,
         15'h5555, 15'h2AAA, 15'h7F00, 15'h00FF
      };
      foreach (directed_angles[k]) begin
         send_angle(directed_angles[k]);
         if (k % 5 == 4) pause_sender($urandom_range(1, 4));
      end
      pause_sender(2);

      // Random part: bursts of random length with random gaps between them;
      // some bursts run long with no gap at all.
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
         for (int n = 0; n < burst && sent < RANDOM_REQUESTS; n++) begin
            send_angle(pick_angle());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
      end
      pause_sender(1);

      // Drain: wait for every expected response, then give the pipeline time to show
      // anything extra it might still emit.
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      if (sb.errors == 0) begin
         $display("[cordic_sine_cosine_unit] OK");
      end else begin
         $display("[cordic_sine_cosine_unit] ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/csc_pkg.sv
sv/csc_if.sv
sv/csc_fold.sv
sv/csc_cell.sv
sv/csc_out.sv
sv/cordic_sine_cosine_unit.sv
tb/sv/tb_top.sv
